@@ src/priority_tx_queue_with_jitter_macros.svh @@
// Assertion helpers
`ifndef PRIORITY_TX_QUEUE_WITH_JITTER_MACROS_SVH
`define PRIORITY_TX_QUEUE_WITH_JITTER_MACROS_SVH
`define PTQ_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lbl failed");
`define PTQ_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lbl failed");
`endif

@@ src/ptq_pkg.sv @@
`default_nettype none
package ptq_pkg;
    localparam int unsigned QUEUE_SLOTS_DEF = 8;
    localparam int unsigned MAX_PAYLOAD_DEF = 64;

    localparam logic [1:0] CMD_ENQ   = 2'd0;
    localparam logic [1:0] CMD_RELAY = 2'd1;
    localparam logic [1:0] CMD_ABORT = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam logic [2:0] REG_NODE_ID = 3'd0;
    localparam logic [2:0] REG_MIN_CRIT = 3'd1;
    localparam logic [2:0] REG_MAX_CRIT = 3'd2;
    localparam logic [2:0] REG_MIN_HIGH = 3'd3;
    localparam logic [2:0] REG_MAX_HIGH = 3'd4;
    localparam logic [2:0] REG_MIN_NORM = 3'd5;
    localparam logic [2:0] REG_MAX_NORM = 3'd6;

    localparam logic [1:0] CLS_RELAY = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_JIT, ST_EMIT, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic jit;
        logic emit;
        logic out;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic busy;
    } t_status;
endpackage
`default_nettype wire

@@ src/ptq_ctrl.sv @@
`default_nettype none
module ptq_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    input  wire            i_out_stall,
    output logic           o_out_valid,
    input  ptq_pkg::t_status i_st,
    output ptq_pkg::t_cmd  o_cmd
);
    import ptq_pkg::*;
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_stall = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                n_state = (i_st.is_tick && !i_st.busy) ? ST_JIT : ST_OUT;
            end
            ST_JIT: begin
                o_cmd.jit = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ src/ptq_datapath.sv @@
`default_nettype none
`include "priority_tx_queue_with_jitter_macros.svh"
module ptq_datapath #(
    parameter int unsigned QUEUE_SLOTS = ptq_pkg::QUEUE_SLOTS_DEF,
    parameter int unsigned MAX_PAYLOAD = ptq_pkg::MAX_PAYLOAD_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  ptq_pkg::t_cmd i_cmd,
    output ptq_pkg::t_status o_st,
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_idx,
    input  wire [15:0] i_cfg_data,
    input  wire [1:0]  i_cmd_f,
    input  wire [7:0]  i_sender_id,
    input  wire [7:0]  i_relay_id_in,
    input  wire [7:0]  i_msg_seq,
    input  wire [3:0]  i_msg_type,
    input  wire [3:0]  i_ttl_in,
    input  wire [1:0]  i_priority_req,
    input  wire [31:0] i_delay_ms,
    input  wire [7:0]  i_payload_length,
    input  wire        i_channel_busy,
    input  wire [15:0] i_rand_value,
    output logic       o_op_ok,
    output logic [2:0] o_slot_index,
    output logic       o_transmit_now,
    output logic [7:0] o_tx_sender_id,
    output logic [7:0] o_tx_relay_id,
    output logic [7:0] o_tx_msg_seq,
    output logic [3:0] o_tx_type,
    output logic [3:0] o_tx_ttl,
    output logic [7:0] o_tx_payload_length,
    output logic [1:0] o_tx_priority
);
    import ptq_pkg::*;
    localparam int unsigned IW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

    logic [7:0]  r_node;
    logic [15:0] r_jmin [3];
    logic [15:0] r_jmax [3];

    logic [QUEUE_SLOTS-1:0] r_valid;
    logic [7:0]  r_snd [QUEUE_SLOTS];
    logic [7:0]  r_rly [QUEUE_SLOTS];
    logic [7:0]  r_seq [QUEUE_SLOTS];
    logic [3:0]  r_typ [QUEUE_SLOTS];
    logic [3:0]  r_ttl [QUEUE_SLOTS];
    logic [1:0]  r_cls [QUEUE_SLOTS];
    logic [7:0]  r_len [QUEUE_SLOTS];
    logic [31:0] r_rdy [QUEUE_SLOTS];

    logic        r_pick_v;
    logic [IW-1:0] r_pick;
    logic [31:0] r_jstart, r_time;
    logic [15:0] r_jwait;

    logic [1:0]  r_c;
    logic [7:0]  r_s, r_r, r_q, r_l;
    logic [3:0]  r_t, r_tt;
    logic [1:0]  r_p;
    logic [31:0] r_d;
    logic        r_b;
    logic [15:0] r_rnd;

    logic        r_found;
    logic [IW-1:0] r_hit;
    logic [1:0]  r_hcls;
    logic [31:0] r_prod;
    logic [15:0] r_lo;
    logic        r_inv;

    assign o_st.is_tick = (r_c == CMD_TICK);
    assign o_st.busy = r_b;

    // scan logic
    logic          s_found;
    logic [IW-1:0] s_idx;
    logic [1:0]    s_cls;
    logic [31:0]   now;
    logic          s_ok;
    assign now = r_time + 32'd1;
    always_comb begin
        s_found = 1'b0;
        s_idx = '0;
        s_cls = CLS_RELAY;
        for (int i = 0; i < QUEUE_SLOTS; i++) begin
            priority if (r_c == CMD_TICK) begin
                if (r_valid[i] && now >= r_rdy[i] && (!s_found || r_cls[i] < s_cls)) begin
                    s_found = 1'b1;
                    s_idx = IW'(i);
                    s_cls = r_cls[i];
                end
            end else if (r_c == CMD_ABORT) begin
                if (!s_found && r_valid[i] && r_snd[i] == r_s && r_seq[i] == r_q) begin
                    s_found = 1'b1;
                    s_idx = IW'(i);
                end
            end else begin
                if (!s_found && !r_valid[i]) begin
                    s_found = 1'b1;
                    s_idx = IW'(i);
                end
            end
        end
    end

    // enqueue accepted or abort matched
    assign s_ok = (r_c == CMD_ABORT) ? s_found :
        ((r_c != CMD_TICK) && s_found && (32'(r_l) <= 32'(MAX_PAYLOAD)));

    logic [15:0] j_lo, j_hi;
    logic [1:0]  j_sel;
    assign j_sel = (r_pick_v ? 2'd0 : s_cls);
    always_comb begin
        j_lo = '0;
        j_hi = '0;
        if (j_sel != CLS_RELAY) begin
            j_lo = r_jmin[j_sel];
            j_hi = r_jmax[j_sel];
        end
    end

    logic [15:0] jw;
    always_comb begin
        if (r_hcls == CLS_RELAY) jw = '0;
        else if (r_inv) jw = r_lo;
        else jw = r_lo + r_prod[31:16];
    end

    logic [31:0] el;
    assign el = r_time - r_jstart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node <= '0;
            r_jmin[0] <= 16'd10;  r_jmax[0] <= 16'd50;
            r_jmin[1] <= 16'd50;  r_jmax[1] <= 16'd150;
            r_jmin[2] <= 16'd100; r_jmax[2] <= 16'd300;
            r_valid <= '0;
            r_pick_v <= 1'b0;
            r_pick <= '0;
            r_jstart <= '0;
            r_jwait <= '0;
            r_time <= '0;
            r_c <= CMD_ENQ;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_NODE_ID:  r_node <= i_cfg_data[7:0];
                    REG_MIN_CRIT: r_jmin[0] <= i_cfg_data;
                    REG_MAX_CRIT: r_jmax[0] <= i_cfg_data;
                    REG_MIN_HIGH: r_jmin[1] <= i_cfg_data;
                    REG_MAX_HIGH: r_jmax[1] <= i_cfg_data;
                    REG_MIN_NORM: r_jmin[2] <= i_cfg_data;
                    REG_MAX_NORM: r_jmax[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_c <= i_cmd_f;
                r_s <= i_sender_id; r_r <= i_relay_id_in; r_q <= i_msg_seq;
                r_t <= i_msg_type; r_tt <= i_ttl_in; r_p <= i_priority_req;
                r_d <= i_delay_ms; r_l <= i_payload_length;
                r_b <= i_channel_busy; r_rnd <= i_rand_value;
            end
            if (i_cmd.scan) begin
                o_op_ok <= s_ok;
                o_slot_index <= s_ok ? 3'(s_idx) : 3'd0;
                o_transmit_now <= 1'b0;
                o_tx_sender_id <= '0; o_tx_relay_id <= '0; o_tx_msg_seq <= '0;
                o_tx_type <= '0; o_tx_ttl <= '0; o_tx_payload_length <= '0;
                o_tx_priority <= '0;
                r_found <= s_found && !r_pick_v;
                r_hit <= s_idx;
                r_hcls <= s_cls;
                r_lo <= j_lo;
                r_inv <= j_hi < j_lo;
                r_prod <= 32'(r_rnd) * 32'(j_hi - j_lo);
                unique case (r_c)
                    CMD_TICK: begin
                        r_time <= now;
                        if (r_b) r_pick_v <= 1'b0;
                    end
                    CMD_ABORT: begin
                        if (s_ok) begin
                            r_valid[s_idx] <= 1'b0;
                            if (r_pick_v && r_pick == s_idx) r_pick_v <= 1'b0;
                        end
                    end
                    default: begin
                        if (s_ok) begin
                            r_valid[s_idx] <= 1'b1;
                            r_snd[s_idx] <= r_s;
                            r_seq[s_idx] <= r_q;
                            r_typ[s_idx] <= r_t;
                            r_len[s_idx] <= r_l;
                            r_rdy[s_idx] <= r_time + r_d;
                            if (r_c == CMD_RELAY) begin
                                r_ttl[s_idx] <= (r_tt != 4'd0) ? r_tt - 4'd1 : 4'd0;
                                r_rly[s_idx] <= r_node;
                                r_cls[s_idx] <= CLS_RELAY;
                            end else begin
                                r_ttl[s_idx] <= r_tt;
                                r_rly[s_idx] <= r_r;
                                r_cls[s_idx] <= r_p;
                            end
                        end
                    end
                endcase
            end
            if (i_cmd.jit && r_found) begin
                r_pick_v <= 1'b1;
                r_pick <= r_hit;
                r_jstart <= r_time;
                r_jwait <= jw;
            end
            if (i_cmd.emit && r_pick_v && el >= 32'(r_jwait)) begin
                r_valid[r_pick] <= 1'b0;
                r_pick_v <= 1'b0;
                o_op_ok <= 1'b1;
                o_slot_index <= 3'(r_pick);
                o_transmit_now <= 1'b1;
                o_tx_sender_id <= r_snd[r_pick];
                o_tx_relay_id <= r_rly[r_pick];
                o_tx_msg_seq <= r_seq[r_pick];
                o_tx_type <= r_typ[r_pick];
                o_tx_ttl <= r_ttl[r_pick];
                o_tx_payload_length <= r_len[r_pick];
                o_tx_priority <= r_cls[r_pick];
            end
        end
    end

    `PTQ_ASSERT_IMP(a_pick_valid_slot, i_clk, i_rst_n, r_pick_v, r_valid[r_pick])
    `PTQ_ASSERT_NXT(a_emit_frees, i_clk, i_rst_n,
        i_cmd.emit && r_pick_v && el >= 32'(r_jwait), !r_pick_v)
    `PTQ_ASSERT_IMP(a_tx_ok, i_clk, i_rst_n, o_transmit_now, o_op_ok)
endmodule
`default_nettype wire

@@ src/priority_tx_queue_with_jitter.sv @@
// Priority transmit queue with per-class random jitter.
// Input channel: i_valid / o_stall with one command per transaction
// (enqueue, relay enqueue, abort, one-millisecond tick) and its fields.
// Output channel: o_valid / i_stall, one result transaction per input.
// Configuration: i_cfg_valid / o_cfg_ready, index and data; write only
// while idle. Always ready.
// Sequencing: the controller steps through register, slot scan, jitter
// draw, emit and output; the jitter draw and emit steps run only for a
// tick with a free channel. o_valid rises in the output step, and no new
// transaction is taken until the receiver has taken the result.
// The slot scan is one combinational priority search over all slots; the
// jitter scaling is one 16x16 multiply registered before its add.
// Reset (synchronous, active low) empties all slots, clears the pick and
// the millisecond counter, and restores default jitter windows.
// While the receiver stalls, the result holds and no new input is taken.
`default_nettype none
module priority_tx_queue_with_jitter #(
    parameter int unsigned QUEUE_SLOTS = ptq_pkg::QUEUE_SLOTS_DEF,
    parameter int unsigned MAX_PAYLOAD = ptq_pkg::MAX_PAYLOAD_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire [1:0]  i_cmd,
    input  wire [7:0]  i_sender_id,
    input  wire [7:0]  i_relay_id_in,
    input  wire [7:0]  i_msg_seq,
    input  wire [3:0]  i_msg_type,
    input  wire [3:0]  i_ttl_in,
    input  wire [1:0]  i_priority_req,
    input  wire [31:0] i_delay_ms,
    input  wire [7:0]  i_payload_length,
    input  wire        i_channel_busy,
    input  wire [15:0] i_rand_value,
    output logic       o_valid,
    input  wire        i_stall,
    output logic       o_op_ok,
    output logic [2:0] o_slot_index,
    output logic       o_transmit_now,
    output logic [7:0] o_tx_sender_id,
    output logic [7:0] o_tx_relay_id,
    output logic [7:0] o_tx_msg_seq,
    output logic [3:0] o_tx_type,
    output logic [3:0] o_tx_ttl,
    output logic [7:0] o_tx_payload_length,
    output logic [1:0] o_tx_priority,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [2:0]  i_cfg_index,
    input  wire [15:0] i_cfg_data
);
    import ptq_pkg::*;
    t_cmd    cmd;
    t_status st;

    assign o_cfg_ready = 1'b1;

    ptq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_out_stall(i_stall), .o_out_valid(o_valid),
        .i_st(st), .o_cmd(cmd)
    );

    ptq_datapath #(.QUEUE_SLOTS(QUEUE_SLOTS), .MAX_PAYLOAD(MAX_PAYLOAD)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_st(st),
        .i_cfg_we(i_cfg_valid), .i_cfg_idx(i_cfg_index), .i_cfg_data,
        .i_cmd_f(i_cmd), .i_sender_id, .i_relay_id_in, .i_msg_seq, .i_msg_type,
        .i_ttl_in, .i_priority_req, .i_delay_ms, .i_payload_length,
        .i_channel_busy, .i_rand_value,
        .o_op_ok, .o_slot_index, .o_transmit_now, .o_tx_sender_id,
        .o_tx_relay_id, .o_tx_msg_seq, .o_tx_type, .o_tx_ttl,
        .o_tx_payload_length, .o_tx_priority
    );
endmodule
`default_nettype wire

@@ tb/priority_tx_queue_with_jitter_tb.sv @@
`default_nettype none
module priority_tx_queue_with_jitter_tb;
    import ptq_pkg::*;

    localparam int NSLOT = 8;
    localparam int MAXLEN = 64;
    localparam int WDOG_LIMIT = 6000;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  sender;
        logic [7:0]  relay;
        logic [7:0]  seq;
        logic [3:0]  mtype;
        logic [3:0]  ttl;
        logic [1:0]  prio;
        logic [31:0] delay;
        logic [7:0]  len;
        logic        busy;
        logic [15:0] rnd;
    } pkt_cmd_t;

    typedef struct {
        logic       ok;
        logic [2:0] idx;
        logic       tx;
        logic [7:0] sender;
        logic [7:0] relay;
        logic [7:0] seq;
        logic [3:0] mtype;
        logic [3:0] ttl;
        logic [7:0] len;
        logic [1:0] prio;
    } tx_res_t;

    class ptq_scoreboard;
        logic [7:0]  node_id;
        logic [15:0] jmin[3];
        logic [15:0] jmax[3];
        bit          occ[NSLOT];
        tx_res_t     hdr[NSLOT];
        logic [31:0] ready_at[NSLOT];
        bit          picked;
        int          pick_slot;
        logic [31:0] jit_start;
        logic [15:0] jit_wait;
        logic [31:0] now_ms;
        tx_res_t     expected_q[$];
        int          errors;

        function void init();
            node_id = 8'd0;
            jmin[0] = 16'd10;  jmax[0] = 16'd50;
            jmin[1] = 16'd50;  jmax[1] = 16'd150;
            jmin[2] = 16'd100; jmax[2] = 16'd300;
            foreach (occ[i]) occ[i] = 1'b0;
            picked = 1'b0; pick_slot = 0; jit_start = '0; jit_wait = '0; now_ms = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                REG_NODE_ID:  node_id = data[7:0];
                REG_MIN_CRIT: jmin[0] = data;
                REG_MAX_CRIT: jmax[0] = data;
                REG_MIN_HIGH: jmin[1] = data;
                REG_MAX_HIGH: jmax[1] = data;
                REG_MIN_NORM: jmin[2] = data;
                REG_MAX_NORM: jmax[2] = data;
                default: ;
            endcase
        endfunction

        function logic [15:0] draw_jitter(logic [1:0] cls, logic [15:0] r);
            logic [63:0] prod;
            if (cls == CLS_RELAY) return 16'd0;
            if (jmax[cls] < jmin[cls]) return jmin[cls];
            prod = 64'(r) * 64'(jmax[cls] - jmin[cls]);
            return jmin[cls] + 16'(prod >> 16);
        endfunction

        function void note_input(pkt_cmd_t c);
            tx_res_t r;
            int best;
            r = '{default: '0};
            if (c.cmd == CMD_ENQ || c.cmd == CMD_RELAY) begin
                if (c.len <= MAXLEN) begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!occ[i]) begin
                            hdr[i] = '{default: '0};
                            hdr[i].sender = c.sender;
                            hdr[i].seq = c.seq;
                            hdr[i].mtype = c.mtype;
                            hdr[i].len = c.len;
                            ready_at[i] = now_ms + c.delay;
                            if (c.cmd == CMD_RELAY) begin
                                hdr[i].ttl = (c.ttl > 0) ? c.ttl - 4'd1 : 4'd0;
                                hdr[i].relay = node_id;
                                hdr[i].prio = CLS_RELAY;
                            end else begin
                                hdr[i].ttl = c.ttl;
                                hdr[i].relay = c.relay;
                                hdr[i].prio = c.prio;
                            end
                            occ[i] = 1'b1;
                            r.ok = 1'b1;
                            r.idx = 3'(i);
                            break;
                        end
                    end
                end
            end else if (c.cmd == CMD_ABORT) begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (occ[i] && hdr[i].sender == c.sender && hdr[i].seq == c.seq) begin
                        occ[i] = 1'b0;
                        if (picked && pick_slot == i) picked = 1'b0;
                        r.ok = 1'b1;
                        r.idx = 3'(i);
                        break;
                    end
                end
            end else begin
                now_ms = now_ms + 32'd1;
                if (c.busy) begin
                    picked = 1'b0;
                end else begin
                    if (!picked) begin
                        best = -1;
                        for (int i = 0; i < NSLOT; i++)
                            if (occ[i] && now_ms >= ready_at[i])
                                if (best < 0 || hdr[i].prio < hdr[best].prio) best = i;
                        if (best >= 0) begin
                            picked = 1'b1;
                            pick_slot = best;
                            jit_start = now_ms;
                            jit_wait = draw_jitter(hdr[best].prio, c.rnd);
                        end
                    end
                    if (picked && (now_ms - jit_start) >= 32'(jit_wait)) begin
                        r = hdr[pick_slot];
                        r.ok = 1'b1;
                        r.idx = 3'(pick_slot);
                        r.tx = 1'b1;
                        occ[pick_slot] = 1'b0;
                        picked = 1'b0;
                    end
                end
            end
            expected_q.push_back(r);
        endfunction

        function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(tx_res_t a);
            tx_res_t e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result transaction", $time);
                return;
            end
            e = expected_q.pop_front();
            cmp("op_ok", 32'(e.ok), 32'(a.ok));
            cmp("slot_index", 32'(e.idx), 32'(a.idx));
            cmp("transmit_now", 32'(e.tx), 32'(a.tx));
            cmp("tx_sender_id", 32'(e.sender), 32'(a.sender));
            cmp("tx_relay_id", 32'(e.relay), 32'(a.relay));
            cmp("tx_msg_seq", 32'(e.seq), 32'(a.seq));
            cmp("tx_type", 32'(e.mtype), 32'(a.mtype));
            cmp("tx_ttl", 32'(e.ttl), 32'(a.ttl));
            cmp("tx_payload_length", 32'(e.len), 32'(a.len));
            cmp("tx_priority", 32'(e.prio), 32'(a.prio));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_cmd = CMD_TICK;
    logic [7:0]  i_sender_id = '0;
    logic [7:0]  i_relay_id_in = '0;
    logic [7:0]  i_msg_seq = '0;
    logic [3:0]  i_msg_type = '0;
    logic [3:0]  i_ttl_in = '0;
    logic [1:0]  i_priority_req = '0;
    logic [31:0] i_delay_ms = '0;
    logic [7:0]  i_payload_length = '0;
    logic        i_channel_busy = 1'b0;
    logic [15:0] i_rand_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_op_ok;
    logic [2:0]  o_slot_index;
    logic        o_transmit_now;
    logic [7:0]  o_tx_sender_id, o_tx_relay_id, o_tx_msg_seq, o_tx_payload_length;
    logic [3:0]  o_tx_type, o_tx_ttl;
    logic [1:0]  o_tx_priority;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    priority_tx_queue_with_jitter dut (.*);

    ptq_scoreboard sb = new();
    int results_seen = 0;
    int idle_cycles = 0;

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result('{o_op_ok, o_slot_index, o_transmit_now, o_tx_sender_id,
                o_tx_relay_id, o_tx_msg_seq, o_tx_type, o_tx_ttl,
                o_tx_payload_length, o_tx_priority});
            results_seen++;
        end
    end

    // receiver stall pattern, plus one long hold-off
    int rx_mode = 0, rx_left = 0, hold_left = 0;
    bit held = 1'b0;
    always @(posedge i_clk) begin
        if (!held && results_seen >= 600) begin
            held = 1'b1;
            hold_left = 400;
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(20, 80);
        end else begin
            rx_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            case (rx_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("priority_tx_queue_with_jitter test failed");
            $finish;
        end
    end

    task automatic send(pkt_cmd_t c);
        i_valid <= 1'b1;
        i_cmd <= c.cmd;
        i_sender_id <= c.sender;
        i_relay_id_in <= c.relay;
        i_msg_seq <= c.seq;
        i_msg_type <= c.mtype;
        i_ttl_in <= c.ttl;
        i_priority_req <= c.prio;
        i_delay_ms <= c.delay;
        i_payload_length <= c.len;
        i_channel_busy <= c.busy;
        i_rand_value <= c.rnd;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        sb.note_input(c);
    endtask

    task automatic pause_sender(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // leaves i_cfg_valid high; the caller drops it after the last write
    task automatic write_cfg(logic [2:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        sb.write_reg(idx, data);
    endtask

    task automatic set_windows(logic [7:0] node, logic [15:0] a, logic [15:0] b,
                               logic [15:0] c, logic [15:0] d, logic [15:0] e,
                               logic [15:0] f);
        wait_drained();
        write_cfg(REG_NODE_ID, {8'd0, node});
        write_cfg(REG_MIN_CRIT, a);
        write_cfg(REG_MAX_CRIT, b);
        write_cfg(REG_MIN_HIGH, c);
        write_cfg(REG_MAX_HIGH, d);
        write_cfg(REG_MIN_NORM, e);
        write_cfg(REG_MAX_NORM, f);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic pkt_cmd_t mk(logic [1:0] cmd, logic [7:0] snd, logic [7:0] seq,
                                    logic [1:0] prio, logic [31:0] dly, logic [7:0] len,
                                    logic [3:0] ttl, logic busy, logic [15:0] rnd);
        pkt_cmd_t c;
        c.cmd = cmd; c.sender = snd; c.relay = 8'hA5 ^ snd; c.seq = seq;
        c.mtype = seq[3:0]; c.ttl = ttl; c.prio = prio; c.delay = dly; c.len = len;
        c.busy = busy; c.rnd = rnd;
        return c;
    endfunction

    function automatic pkt_cmd_t rand_cmd();
        pkt_cmd_t c;
        int sel;
        sel = $urandom_range(0, 99);
        c.cmd = sel < 45 ? CMD_TICK : sel < 70 ? CMD_ENQ : sel < 85 ? CMD_RELAY : CMD_ABORT;
        if ($urandom_range(0, 4) != 0) begin
            c.sender = 8'($urandom_range(0, 3));
            c.seq = 8'($urandom_range(0, 3));
        end else begin
            c.sender = 8'($urandom);
            c.seq = 8'($urandom);
        end
        c.relay = 8'($urandom);
        c.mtype = 4'($urandom);
        c.ttl = 4'($urandom);
        c.prio = 2'($urandom);
        sel = $urandom_range(0, 9);
        c.delay = sel < 7 ? $urandom_range(0, 15) : sel < 9 ? $urandom_range(0, 300) : $urandom;
        c.len = $urandom_range(0, 6) != 0 ? 8'($urandom_range(0, MAXLEN)) : 8'($urandom);
        c.busy = ($urandom_range(0, 9) == 0);
        c.rnd = 16'($urandom);
        return c;
    endfunction

    task automatic run_random(int count);
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && count > 0) begin
                send(rand_cmd());
                burst--;
                count--;
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
        end
    endtask

    initial begin
        sb.init();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        send(mk(CMD_ENQ, 8'h00, 8'h00, 2'd2, 32'd0, 8'd0, 4'd0, 1'b0, 16'h0000));
        send(mk(CMD_ENQ, 8'hFF, 8'hFF, 2'd0, 32'd3, 8'd64, 4'd15, 1'b0, 16'h0000));
        send(mk(CMD_ENQ, 8'h11, 8'h22, 2'd1, 32'd0, 8'd65, 4'd3, 1'b0, 16'h0000));
        send(mk(CMD_ENQ, 8'h12, 8'h23, 2'd3, 32'hFFFF_FFFF, 8'd255, 4'd3, 1'b0, 16'h0000));
        send(mk(CMD_RELAY, 8'h13, 8'h24, 2'd0, 32'd1, 8'd10, 4'd0, 1'b0, 16'h0000));
        send(mk(CMD_RELAY, 8'h14, 8'h25, 2'd0, 32'd0, 8'd20, 4'd15, 1'b0, 16'h0000));
        send(mk(CMD_ENQ, 8'h15, 8'h26, 2'd1, 32'hFFFF_FFFF, 8'd5, 4'd7, 1'b0, 16'h0000));
        send(mk(CMD_ENQ, 8'h16, 8'h27, 2'd3, 32'd0, 8'd5, 4'd7, 1'b0, 16'h0000));
        send(mk(CMD_ENQ, 8'h17, 8'h28, 2'd2, 32'd0, 8'd5, 4'd7, 1'b0, 16'h0000));
        send(mk(CMD_ENQ, 8'h18, 8'h29, 2'd2, 32'd0, 8'd5, 4'd7, 1'b0, 16'h0000));
        send(mk(CMD_ABORT, 8'h99, 8'h99, 2'd0, 32'd0, 8'd0, 4'd0, 1'b0, 16'h0000));
        send(mk(CMD_ABORT, 8'h15, 8'h26, 2'd0, 32'd0, 8'd0, 4'd0, 1'b0, 16'h0000));
        send(mk(CMD_TICK, 8'h00, 8'h00, 2'd0, 32'd0, 8'd0, 4'd0, 1'b1, 16'hFFFF));
        send(mk(CMD_TICK, 8'h00, 8'h00, 2'd0, 32'd0, 8'd0, 4'd0, 1'b0, 16'hFFFF));
        send(mk(CMD_ABORT, 8'h14, 8'h25, 2'd0, 32'd0, 8'd0, 4'd0, 1'b0, 16'h0000));
        send(mk(CMD_TICK, 8'h00, 8'h00, 2'd0, 32'd0, 8'd0, 4'd0, 1'b0, 16'h0000));
        send(mk(CMD_TICK, 8'h00, 8'h00, 2'd0, 32'd0, 8'd0, 4'd0, 1'b1, 16'h0000));
        repeat (8) send(mk(CMD_TICK, 8'h00, 8'h00, 2'd0, 32'd0, 8'd0, 4'd0, 1'b0, 16'h8000));

        // random phases over several jitter settings
        run_random(300);
        set_windows(8'hFF, 16'd0, 16'd0, 16'd0, 16'd4, 16'd2, 16'd9);
        run_random(400);
        set_windows(8'h5A, 16'd3, 16'd1, 16'd0, 16'd65535, 16'd65535, 16'd65535);
        run_random(250);
        set_windows(8'h00, 16'd1, 16'd6, 16'd65535, 16'd0, 16'd4, 16'd12);
        run_random(400);
        set_windows(8'hA5, 16'd0, 16'd20, 16'd5, 16'd30, 16'd10, 16'd40);
        run_random(350);

        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("priority_tx_queue_with_jitter test passed");
        else
            $display("priority_tx_queue_with_jitter test failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+src
src/ptq_pkg.sv
src/ptq_ctrl.sv
src/ptq_datapath.sv
src/priority_tx_queue_with_jitter.sv
tb/priority_tx_queue_with_jitter_tb.sv
